// File: sv/vlmq_pkg.sv
// Shared constants, codes and handshake structs for the variable-length message queue.
package vlmq_pkg;

  // Store geometry.
  localparam int QueueBytes  = 4096;
  localparam int QueueWords  = QueueBytes / 4;
  localparam int AddrW       = $clog2(QueueWords);
  localparam int PtrW        = AddrW + 1;
  localparam int HdrBytes    = 8;
  localparam int HdrWords    = (HdrBytes + 3) / 4;
  localparam int MaxMsgBytes = 256;

  // Field widths.
  localparam int LenW   = 9;
  localparam int CapW   = 13;
  localparam int WordW  = 32;
  localparam int HeldW  = 10;
  localparam int NWordW = 7;

  typedef enum logic [1:0] {
    OP_ENQ_START = 2'd0,
    OP_ENQ_DATA  = 2'd1,
    OP_DEQ       = 2'd2,
    OP_UNUSED    = 2'd3
  } vlmq_op_e;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_NO_SPACE   = 3'd1,
    STS_EMPTY      = 3'd2,
    STS_BUF_SMALL  = 3'd3,
    STS_SEQ_ERROR  = 3'd4
  } vlmq_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HDR,
    ST_STREAM
  } vlmq_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_en;   // capture the accepted request
    logic exec_en;  // carry out the captured request
    logic hdr_en;   // act on the header word just read
    logic word_en;  // emit the data word just read
  } vlmq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;       // output register can take a result this cycle
    logic exec_emits;      // the captured request gives a result now
    logic exec_reads_hdr;  // the captured request is a dequeue that proceeds
    logic hdr_streams;     // the header leads to data words
    logic word_last;       // the current data word is the final one
  } vlmq_sts_t;

  // Number of whole words that hold a message of len bytes (len up to the maximum).
  function automatic logic [NWordW-1:0] words_of(input logic [LenW-1:0] len);
    logic [LenW:0] rounded;
    rounded = {1'b0, len} + (LenW+1)'(3);
    return rounded[NWordW+1:2];
  endfunction

endpackage

// File: sv/vlmq_ctrl.sv
// Sequencing state machine of the variable-length message queue.
module vlmq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vlmq_pkg::vlmq_sts_t sts_i,
  output vlmq_pkg::vlmq_cmd_t cmd_o
);
  import vlmq_pkg::*;

  vlmq_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts_i.exec_reads_hdr) begin
          state_d = ST_HDR;
        end else if (!sts_i.exec_emits || sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (sts_i.hdr_streams) begin
          state_d = ST_STREAM;
        end else if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_STREAM: begin
        if (sts_i.slot_free && sts_i.word_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and input handshake.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.cap_en = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec_en = sts_i.exec_reads_hdr || !sts_i.exec_emits || sts_i.slot_free;
      end
      ST_HDR: begin
        cmd_o.hdr_en = sts_i.hdr_streams || sts_i.slot_free;
      end
      ST_STREAM: begin
        cmd_o.word_en = sts_i.slot_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: sv/vlmq_dp.sv
// Datapath of the variable-length message queue: pointers, word store and result register.
module vlmq_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vlmq_pkg::CapW-1:0]    cfg_usable_bytes_i,
  input  logic [1:0]                   opcode_i,
  input  logic [vlmq_pkg::LenW-1:0]    msg_length_i,
  input  logic [vlmq_pkg::WordW-1:0]   data_word_i,
  input  logic [vlmq_pkg::CapW-1:0]    buffer_capacity_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [vlmq_pkg::WordW-1:0]   out_word_o,
  output logic [vlmq_pkg::LenW-1:0]    byte_count_o,
  output logic                         last_o,
  output logic [vlmq_pkg::HeldW-1:0]   messages_held_o,
  input  vlmq_pkg::vlmq_cmd_t          cmd_i,
  output vlmq_pkg::vlmq_sts_t          sts_o
);
  import vlmq_pkg::*;

  // Word store.
  logic [WordW-1:0] mem_q [QueueWords];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [WordW-1:0] mem_wdata;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [WordW-1:0] rd_data_q;

  // Queue state.
  logic [CapW-1:0]   usable_q;
  logic [PtrW-1:0]   wp_q, wp_d;
  logic [PtrW-1:0]   rp_q, rp_d;
  logic [HeldW-1:0]  count_q, count_d;
  logic [NWordW-1:0] wexp_q, wexp_d;
  logic [LenW-1:0]   pend_q, pend_d;
  logic [AddrW-1:0]  wr_addr_q, wr_addr_d;

  // Captured request.
  vlmq_op_e          op_q, op_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [WordW-1:0]  word_q, word_d;
  logic [CapW-1:0]   cap_q, cap_d;

  // Dequeue stream.
  logic [AddrW-1:0]  st_addr_q, st_addr_d;
  logic [NWordW-1:0] st_left_q, st_left_d;
  logic [LenW-1:0]   cur_len_q, cur_len_d;

  // Result register.
  logic              out_valid_q, out_valid_d;
  vlmq_status_e      out_status_q;
  logic [WordW-1:0]  out_word_q;
  logic [LenW-1:0]   out_count_q;
  logic              out_last_q;
  logic [HeldW-1:0]  out_held_q;

  logic              load;
  vlmq_status_e      ld_status;
  logic [WordW-1:0]  ld_word;
  logic [LenW-1:0]   ld_count;
  logic              ld_last;

  // Derived values.
  logic              filling;
  logic [CapW-1:0]   limit, wp_bytes, remaining;
  logic [LenW:0]     padded_len;
  logic [LenW+1:0]   total;
  logic              start_fail;
  logic [NWordW-1:0] start_words, pend_words;
  logic [WordW-1:0]  masked_word;
  logic [LenW-1:0]   mlen;
  logic [NWordW-1:0] mlen_words;
  logic              too_small;
  logic [PtrW-1:0]   rp_next;
  logic              slot_free;

  // Space check, header decode and pad masking.
  always_comb begin
    filling     = (wexp_q != '0);
    limit       = (usable_q > CapW'(QueueBytes)) ? CapW'(QueueBytes) : usable_q;
    wp_bytes    = {wp_q, 2'b00};
    remaining   = (limit > wp_bytes) ? (limit - wp_bytes) : '0;
    padded_len  = ({1'b0, len_q} + (LenW+1)'(3)) & ~(LenW+1)'(3);
    total       = (LenW+2)'(HdrBytes) + {1'b0, padded_len};
    start_fail  = (len_q > LenW'(MaxMsgBytes)) || (remaining < CapW'(total));
    start_words = words_of(len_q);
    pend_words  = words_of(pend_q);

    masked_word = word_q;
    if (wexp_q == NWordW'(1)) begin
      case (pend_q[1:0])
        2'd1:    masked_word = {24'd0, word_q[7:0]};
        2'd2:    masked_word = {16'd0, word_q[15:0]};
        2'd3:    masked_word = {8'd0, word_q[23:0]};
        default: masked_word = word_q;
      endcase
    end

    mlen       = (rd_data_q[LenW-1:0] > LenW'(MaxMsgBytes)) ? LenW'(MaxMsgBytes)
                                                            : rd_data_q[LenW-1:0];
    mlen_words = words_of(mlen);
    too_small  = ({{(CapW-LenW){1'b0}}, mlen} > cap_q);
    rp_next    = rp_q + PtrW'(HdrWords) + {{(PtrW-NWordW){1'b0}}, mlen_words};
    slot_free  = !out_valid_q || !out_stall_i;
  end

  // Status toward the controller.
  always_comb begin
    sts_o.slot_free      = slot_free;
    sts_o.exec_reads_hdr = (op_q == OP_DEQ) && !filling && (count_q != '0);
    sts_o.hdr_streams    = !too_small && (mlen_words != '0);
    sts_o.word_last      = (st_left_q == NWordW'(1));
    unique case (op_q)
      OP_ENQ_START: sts_o.exec_emits = filling || start_fail || (start_words == '0);
      OP_ENQ_DATA:  sts_o.exec_emits = !filling || (wexp_q == NWordW'(1));
      OP_DEQ:       sts_o.exec_emits = filling || (count_q == '0);
      OP_UNUSED:    sts_o.exec_emits = 1'b1;
      default:      sts_o.exec_emits = 1'b1;
    endcase
  end

  // Next values for the request in hand.
  always_comb begin
    op_d      = op_q;
    len_d     = len_q;
    word_d    = word_q;
    cap_d     = cap_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    count_d   = count_q;
    wexp_d    = wexp_q;
    pend_d    = pend_q;
    wr_addr_d = wr_addr_q;
    st_addr_d = st_addr_q;
    st_left_d = st_left_q;
    cur_len_d = cur_len_q;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = masked_word;
    rd_en     = 1'b0;
    rd_addr   = rp_q[AddrW-1:0];
    load      = 1'b0;
    ld_status = STS_OK;
    ld_word   = '0;
    ld_count  = '0;
    ld_last   = 1'b1;

    if (cmd_i.cap_en) begin
      op_d   = vlmq_op_e'(opcode_i);
      len_d  = msg_length_i;
      word_d = data_word_i;
      cap_d  = buffer_capacity_i;
    end

    if (cmd_i.exec_en) begin
      unique case (op_q)
        OP_ENQ_START: begin
          if (filling) begin
            load      = 1'b1;
            ld_status = STS_SEQ_ERROR;
          end else if (start_fail) begin
            load      = 1'b1;
            ld_status = STS_NO_SPACE;
            ld_count  = len_q;
          end else begin
            // Header word holds the length; the data follows it.
            mem_we    = 1'b1;
            mem_waddr = wp_q[AddrW-1:0];
            mem_wdata = {{(WordW-LenW){1'b0}}, len_q};
            pend_d    = len_q;
            wexp_d    = start_words;
            wr_addr_d = wp_q[AddrW-1:0] + AddrW'(HdrWords);
            if (start_words == '0) begin
              wp_d      = wp_q + PtrW'(HdrWords);
              count_d   = count_q + HeldW'(1);
              load      = 1'b1;
              ld_count  = len_q;
            end
          end
        end
        OP_ENQ_DATA: begin
          if (!filling) begin
            load      = 1'b1;
            ld_status = STS_SEQ_ERROR;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr_q;
            mem_wdata = masked_word;
            wexp_d    = wexp_q - NWordW'(1);
            wr_addr_d = wr_addr_q + AddrW'(1);
            if (wexp_q == NWordW'(1)) begin
              wp_d     = wp_q + PtrW'(HdrWords) + {{(PtrW-NWordW){1'b0}}, pend_words};
              count_d  = count_q + HeldW'(1);
              load     = 1'b1;
              ld_count = pend_q;
            end
          end
        end
        OP_DEQ: begin
          if (filling) begin
            load      = 1'b1;
            ld_status = STS_SEQ_ERROR;
          end else if (count_q == '0) begin
            load      = 1'b1;
            ld_status = STS_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = rp_q[AddrW-1:0];
          end
        end
        OP_UNUSED: begin
          load      = 1'b1;
          ld_status = STS_SEQ_ERROR;
        end
        default: begin
          load      = 1'b1;
          ld_status = STS_SEQ_ERROR;
        end
      endcase
    end

    // Header of the message at the read pointer.
    if (cmd_i.hdr_en) begin
      if (too_small) begin
        load      = 1'b1;
        ld_status = STS_BUF_SMALL;
        ld_count  = mlen;
      end else begin
        if (rp_next == wp_q) begin
          rp_d = '0;
          wp_d = '0;
        end else begin
          rp_d = rp_next;
        end
        count_d = count_q - HeldW'(1);
        if (mlen_words == '0) begin
          load     = 1'b1;
          ld_count = mlen;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = rp_q[AddrW-1:0] + AddrW'(HdrWords);
          st_addr_d = rp_q[AddrW-1:0] + AddrW'(HdrWords);
          st_left_d = mlen_words;
          cur_len_d = mlen;
        end
      end
    end

    // One data word per cycle while the output register is free, reading the next one ahead.
    if (cmd_i.word_en) begin
      load     = 1'b1;
      ld_word  = rd_data_q;
      ld_count = cur_len_q;
      ld_last  = (st_left_q == NWordW'(1));
      if (st_left_q != NWordW'(1)) begin
        rd_en     = 1'b1;
        rd_addr   = st_addr_q + AddrW'(1);
        st_addr_d = st_addr_q + AddrW'(1);
        st_left_d = st_left_q - NWordW'(1);
      end
    end

    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_q    <= CapW'(QueueBytes);
      wp_q        <= '0;
      rp_q        <= '0;
      count_q     <= '0;
      wexp_q      <= '0;
      pend_q      <= '0;
      op_q        <= OP_ENQ_START;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) usable_q <= cfg_usable_bytes_i;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      count_q     <= count_d;
      wexp_q      <= wexp_d;
      pend_q      <= pend_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    len_q     <= len_d;
    word_q    <= word_d;
    cap_q     <= cap_d;
    wr_addr_q <= wr_addr_d;
    st_addr_q <= st_addr_d;
    st_left_q <= st_left_d;
    cur_len_q <= cur_len_d;
    if (load) begin
      out_status_q <= ld_status;
      out_word_q   <= ld_word;
      out_count_q  <= ld_count;
      out_last_q   <= ld_last;
      out_held_q   <= count_d;
    end
  end

  // Store write port.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
  end

  // Store read port with registered data.
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_word_o      = out_word_q;
  assign byte_count_o    = out_count_q;
  assign last_o          = out_last_q;
  assign messages_held_o = out_held_q;

endmodule

// File: sv/variable_length_message_queue.sv
// Top level of the variable-length message queue: controller plus datapath.
// A request is captured in the idle state and carried out in the execute state,
// which waits for a free result register if it gives a result; enqueues and
// empty or sequence-error results end there. A dequeue reads and checks the
// header, then streams one data word per cycle while the output is free.
// Reset clears the pointers, message count, fill state and limit (4096 bytes);
// the word store is not cleared and needs no clearing pass.
module variable_length_message_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [vlmq_pkg::CapW-1:0]    cfg_usable_bytes_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [vlmq_pkg::LenW-1:0]    msg_length_i,
  input  logic [vlmq_pkg::WordW-1:0]   data_word_i,
  input  logic [vlmq_pkg::CapW-1:0]    buffer_capacity_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [vlmq_pkg::WordW-1:0]   out_word_o,
  output logic [vlmq_pkg::LenW-1:0]    byte_count_o,
  output logic                         last_o,
  output logic [vlmq_pkg::HeldW-1:0]   messages_held_o
);
  import vlmq_pkg::*;

  vlmq_cmd_t cmd;
  vlmq_sts_t sts;

  // The limit register accepts a write in any cycle.
  assign cfg_ready_o = 1'b1;

  vlmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vlmq_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_usable_bytes_i (cfg_usable_bytes_i),
    .opcode_i           (opcode_i),
    .msg_length_i       (msg_length_i),
    .data_word_i        (data_word_i),
    .buffer_capacity_i  (buffer_capacity_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .status_o           (status_o),
    .out_word_o         (out_word_o),
    .byte_count_o       (byte_count_o),
    .last_o             (last_o),
    .messages_held_o    (messages_held_o),
    .cmd_i              (cmd),
    .sts_o              (sts)
  );

endmodule
